>>> hdl/sll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_pkg
// shared types and codes for the array linked list engine
// ----------------------------------------------------------------------------
package sll_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_LOCATE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         position;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_slot;
    logic [7:0]         found_position;
    logic [7:0]         list_length;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_SCAN_WAIT,
    S_WALK,
    S_WALK_WAIT,
    S_LINK_RD,
    S_LINK_WAIT,
    S_VAL_WAIT,
    S_WRITE2,
    S_DONE
  } back_state_t;

endpackage

>>> hdl/sll_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module sll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hdl/sll_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_front
// input stage and two entry queue towards the list sequencer
// ----------------------------------------------------------------------------
module sll_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sll_pkg::in_word_t in_data,
  output logic              q_valid,
  input  logic              q_take,
  output sll_pkg::in_word_t q_data
);

  sll_pkg::in_word_t buf_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (q_take) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_take);
    end
  end

endmodule

>>> hdl/sll_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_back
// list sequencer: free slot scan, link walk and relink over the node stores
// ----------------------------------------------------------------------------
module sll_back #(
  parameter int NODES      = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_take,
  input  sll_pkg::in_word_t  q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sll_pkg::out_word_t out_data
);

  localparam int AW = $clog2(NODES);
  localparam int LW = AW + 2;   // link: {unused, end, slot}
  localparam int CW = ($clog2(NODES + 1) > 9) ? $clog2(NODES + 1) : 9;

  sll_pkg::back_state_t state_r, state_nxt;

  logic [AW-1:0]         la, va;
  logic                  lwe, vwe;
  logic [LW-1:0]         lwd, lrd;
  logic [VALUE_BITS-1:0] vwd, vrd;

  sll_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link (
    .clk(clk), .we(lwe), .addr(la), .wdata(lwd), .rdata(lrd));
  sll_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODES)) u_val (
    .clk(clk), .we(vwe), .addr(va), .wdata(vwd), .rdata(vrd));

  sll_pkg::in_word_t  cmd_r, cmd_nxt;
  sll_pkg::out_word_t res_r, res_nxt;
  logic               ov_r, ov_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic [AW-1:0]      fresh_r, fresh_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [LW-1:0]      held_r, held_nxt;

  logic [CW-1:0]         pos_c;
  logic [VALUE_BITS-1:0] key;
  logic [AW-1:0]         lslot;
  logic                  lunused, lend;

  assign pos_c    = CW'(cmd_r.position);
  assign key      = VALUE_BITS'(cmd_r.item_value);
  assign lslot    = lrd[AW-1:0];
  assign lunused  = lrd[AW+1];
  assign lend     = lrd[AW];
  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    res_r   <= res_nxt;
    cur_r   <= cur_nxt;
    fresh_r <= fresh_nxt;
    k_r     <= k_nxt;
    held_r  <= held_nxt;
    if (!rst_n) begin
      state_r <= sll_pkg::S_CLEAR;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && out_stall;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    fresh_nxt = fresh_r;
    k_nxt     = k_r;
    held_nxt  = held_r;
    q_take    = 1'b0;
    la        = idx_r;
    va        = idx_r;
    lwe       = 1'b0;
    vwe       = 1'b0;
    lwd       = '0;
    vwd       = key;
    unique case (state_r)
      sll_pkg::S_CLEAR: begin
        lwe = 1'b1;
        lwd = (idx_r == '0) ? {2'b01, AW'(0)} : {2'b10, AW'(0)};
        idx_nxt = idx_r + 1'b1;
        if (idx_r == AW'(NODES - 1)) begin
          state_nxt = sll_pkg::S_IDLE;
        end
      end
      sll_pkg::S_IDLE: begin
        if (q_valid && !ov_r) begin
          q_take  = 1'b1;
          cmd_nxt = q_data;
          res_nxt = '0;
          res_nxt.list_length = 8'(cnt_r);
          la = '0;
          k_nxt = CW'(1);
          unique case (sll_pkg::action_t'(q_data.action))
            sll_pkg::ACT_INSERT: begin
              if (q_data.position == 8'd0 || CW'(q_data.position) > cnt_r + 1'b1) begin
                res_nxt.status = sll_pkg::ST_BAD_POS;
                state_nxt = sll_pkg::S_DONE;
              end else begin
                idx_nxt = AW'(1);
                la = AW'(1);
                state_nxt = sll_pkg::S_SCAN;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                res_nxt.status = sll_pkg::ST_EMPTY;
                state_nxt = sll_pkg::S_DONE;
              end else if (q_data.action != sll_pkg::ACT_LOCATE &&
                           (q_data.position == 8'd0 || CW'(q_data.position) > cnt_r)) begin
                res_nxt.status = sll_pkg::ST_BAD_POS;
                state_nxt = sll_pkg::S_DONE;
              end else begin
                cur_nxt = '0;
                state_nxt = sll_pkg::S_WALK_WAIT;
              end
            end
          endcase
        end
      end
      sll_pkg::S_SCAN: begin
        // lrd holds link of idx_r
        if (lunused) begin
          fresh_nxt = idx_r;
          cur_nxt = '0;
          la = '0;
          state_nxt = sll_pkg::S_LINK_WAIT;
          if (pos_c == CW'(1)) begin
            state_nxt = sll_pkg::S_LINK_WAIT;
          end else begin
            state_nxt = sll_pkg::S_WALK_WAIT;
          end
        end else if (idx_r == AW'(NODES - 1)) begin
          res_nxt.status = sll_pkg::ST_FULL;
          state_nxt = sll_pkg::S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          la = idx_r + 1'b1;
          state_nxt = sll_pkg::S_SCAN_WAIT;
        end
      end
      sll_pkg::S_SCAN_WAIT: begin
        la = idx_r;
        state_nxt = sll_pkg::S_SCAN;
      end
      sll_pkg::S_WALK_WAIT: begin
        // link read of cur_r issued last cycle
        la = cur_r;
        state_nxt = sll_pkg::S_WALK;
      end
      sll_pkg::S_WALK: begin
        // lrd = link of cur_r, the slot at position k_r
        la = cur_r;
        if (cmd_r.action == sll_pkg::ACT_INSERT) begin
          // walking to position pos-1
          cur_nxt = lslot;
          la = lslot;
          if (k_r == pos_c - 1'b1) begin
            state_nxt = sll_pkg::S_LINK_WAIT;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = sll_pkg::S_WALK_WAIT;
          end
        end else if (cmd_r.action == sll_pkg::ACT_DELETE) begin
          if (k_r == pos_c) begin
            // cur_r is prev, lslot is victim
            idx_nxt = lslot;
            la = lslot;
            state_nxt = sll_pkg::S_LINK_RD;
          end else begin
            cur_nxt = lslot;
            la = lslot;
            k_nxt = k_r + 1'b1;
            state_nxt = sll_pkg::S_WALK_WAIT;
          end
        end else if (cmd_r.action == sll_pkg::ACT_GET) begin
          cur_nxt = lslot;
          la = lslot;
          va = lslot;
          if (k_r == pos_c) begin
            state_nxt = sll_pkg::S_VAL_WAIT;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = sll_pkg::S_WALK_WAIT;
          end
        end else begin
          // locate: read link and value of the node at k_r
          if (lend || lunused || k_r > cnt_r) begin
            res_nxt.status = sll_pkg::ST_NOT_FOUND;
            state_nxt = sll_pkg::S_DONE;
          end else begin
            cur_nxt = lslot;
            la = lslot;
            va = lslot;
            state_nxt = sll_pkg::S_VAL_WAIT;
          end
        end
      end
      sll_pkg::S_VAL_WAIT: begin
        la = cur_r;
        va = cur_r;
        state_nxt = sll_pkg::S_LINK_RD;
      end
      sll_pkg::S_LINK_RD: begin
        // get/locate: vrd valid; delete: lrd = victim link
        la = cur_r;
        if (cmd_r.action == sll_pkg::ACT_GET) begin
          res_nxt.read_value = 32'(signed'(vrd));
          state_nxt = sll_pkg::S_DONE;
        end else if (cmd_r.action == sll_pkg::ACT_LOCATE) begin
          if (vrd == key) begin
            res_nxt.found_slot = 8'(cur_r);
            res_nxt.found_position = 8'(k_r);
            state_nxt = sll_pkg::S_DONE;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = sll_pkg::S_WALK;
          end
        end else begin
          lwe = 1'b1;
          la  = cur_r;
          lwd = lrd;
          state_nxt = sll_pkg::S_WRITE2;
        end
      end
      sll_pkg::S_LINK_WAIT: begin
        // insert: read of prev link issued
        la = cur_r;
        state_nxt = sll_pkg::S_LINK_RD;
        if (cmd_r.action == sll_pkg::ACT_INSERT) begin
          state_nxt = sll_pkg::S_WRITE2;
          held_nxt = '0;
        end
      end
      sll_pkg::S_WRITE2: begin
        if (cmd_r.action == sll_pkg::ACT_INSERT) begin
          if (held_r == '0 && k_r != '0) begin
            // write fresh node: value and old prev link
            la  = fresh_r;
            va  = fresh_r;
            lwe = 1'b1;
            vwe = 1'b1;
            lwd = lrd;
            k_nxt = '0;
          end else begin
            la  = cur_r;
            lwe = 1'b1;
            lwd = {2'b00, fresh_r};
            cnt_nxt = cnt_r + 1'b1;
            res_nxt.list_length = 8'(cnt_r + 1'b1);
            state_nxt = sll_pkg::S_DONE;
          end
        end else begin
          la  = idx_r;
          lwe = 1'b1;
          lwd = {2'b10, AW'(0)};
          cnt_nxt = cnt_r - 1'b1;
          res_nxt.list_length = 8'(cnt_r - 1'b1);
          state_nxt = sll_pkg::S_DONE;
        end
      end
      sll_pkg::S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = sll_pkg::S_IDLE;
        end
      end
      default: state_nxt = sll_pkg::S_IDLE;
    endcase
  end

endmodule

>>> hdl/array_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine
// linked list kept in a fixed node store, one word at a time
// ----------------------------------------------------------------------------
// one word in flight, set by the single port node stores; the next word is
// taken at the edge after the result word leaves
// after reset a pass clears every link slot before the first word is taken
// reset: synchronous, active low; list empty, queue empty
module array_linked_list_engine #(
  parameter int NODES      = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sll_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sll_pkg::out_word_t out_data
);

  logic              q_valid, q_take;
  sll_pkg::in_word_t q_data;

  sll_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data));

  sll_back #(.NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
    .q_data(q_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data));

endmodule

>>> tb/tb_array_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_engine
// drives insert, delete, get and locate words into the list engine, predicts
// every result word from a private copy of the node store and compares them
// in order, under phases of sender idling and receiver stalling
// ----------------------------------------------------------------------------
module tb_array_linked_list_engine;

  localparam int NODES      = 256;
  localparam int LINK_FREE  = -1;
  localparam int LINK_TAIL  = -2;
  localparam int RAND_WORDS = 140;
  localparam int HOLD_LEN   = 3000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  sll_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  sll_pkg::out_word_t out_data;

  array_linked_list_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  int          node_link [NODES];
  logic [31:0] node_val  [NODES];
  int          elem_count;

  typedef struct {
    sll_pkg::out_word_t want;
    sll_pkg::out_word_t pred;
  } pend_t;

  pend_t       pending_q [$];
  int          mismatches = 0;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_go;
  bit          hold_on;

  typedef struct {
    sll_pkg::in_word_t  word;
    bit                 typed;
    sll_pkg::out_word_t res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // long receiver hold-off
  initial begin
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_on <= 1'b0;
  end

  function automatic int slot_at_pos(int pos);
    int s;
    s = node_link[0];
    for (int k = 1; k < pos; k++) s = (s >= 0) ? node_link[s] : LINK_TAIL;
    return s;
  endfunction

  function automatic sll_pkg::out_word_t list_apply(sll_pkg::in_word_t w);
    sll_pkg::out_word_t r;
    int pos, fresh, prev, cur, s, p;
    r = '0;
    pos = int'(w.position);
    r.status = sll_pkg::ST_OK;
    case (sll_pkg::action_t'(w.action))
      sll_pkg::ACT_INSERT: begin
        if (pos < 1 || pos > elem_count + 1) r.status = sll_pkg::ST_BAD_POS;
        else begin
          fresh = 0;
          for (int i = 1; i < NODES; i++)
            if (fresh == 0 && node_link[i] == LINK_FREE) fresh = i;
          if (fresh == 0) r.status = sll_pkg::ST_FULL;
          else begin
            prev = (pos == 1) ? 0 : slot_at_pos(pos - 1);
            node_val[fresh] = w.item_value;
            node_link[fresh] = node_link[prev];
            node_link[prev] = fresh;
            elem_count++;
          end
        end
      end
      sll_pkg::ACT_DELETE, sll_pkg::ACT_GET: begin
        if (elem_count == 0) r.status = sll_pkg::ST_EMPTY;
        else if (pos < 1 || pos > elem_count) r.status = sll_pkg::ST_BAD_POS;
        else if (w.action == sll_pkg::ACT_DELETE) begin
          prev = (pos == 1) ? 0 : slot_at_pos(pos - 1);
          cur = node_link[prev];
          node_link[prev] = node_link[cur];
          node_link[cur] = LINK_FREE;
          elem_count--;
        end else begin
          r.read_value = node_val[slot_at_pos(pos)];
        end
      end
      default: begin
        if (elem_count == 0) r.status = sll_pkg::ST_EMPTY;
        else begin
          r.status = sll_pkg::ST_NOT_FOUND;
          s = node_link[0];
          p = 1;
          while (s >= 0 && p <= elem_count && r.status != sll_pkg::ST_OK) begin
            if (node_val[s] == w.item_value) begin
              r.status = sll_pkg::ST_OK;
              r.found_slot = 8'(s);
              r.found_position = 8'(p);
            end else begin
              s = node_link[s];
              p++;
            end
          end
        end
      end
    endcase
    r.list_length = 8'(elem_count);
    return r;
  endfunction

  function automatic sll_pkg::in_word_t mk(sll_pkg::action_t a, int pos, logic [31:0] v);
    sll_pkg::in_word_t w;
    w.action = a;
    w.position = 8'(pos);
    w.item_value = v;
    return w;
  endfunction

  function automatic sll_pkg::out_word_t mkr(sll_pkg::status_t st, logic [31:0] rd, int len);
    sll_pkg::out_word_t r;
    r = '0;
    r.status = st;
    r.read_value = rd;
    r.list_length = 8'(len);
    return r;
  endfunction

  task automatic add_row(sll_pkg::in_word_t w, bit typed, sll_pkg::out_word_t r);
    dir_row_t row;
    row.word = w;
    row.typed = typed;
    row.res = r;
    dir_rows.push_back(row);
  endtask

  task automatic send_word(sll_pkg::in_word_t w, bit typed, sll_pkg::out_word_t r);
    pend_t pe;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    pe.pred = list_apply(w);
    pe.want = typed ? r : pe.pred;
    pending_q.push_back(pe);
  endtask

  function automatic sll_pkg::in_word_t rand_word();
    sll_pkg::in_word_t w;
    int sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    v = $urandom;
    if ($urandom_range(3) == 0) v = $urandom_range(7);
    if (sel < 40) w = mk(sll_pkg::ACT_INSERT, $urandom_range(elem_count + 1), v);
    else if (sel < 60) w = mk(sll_pkg::ACT_DELETE, $urandom_range(elem_count + 1), v);
    else if (sel < 80) w = mk(sll_pkg::ACT_GET, $urandom_range(elem_count + 1), v);
    else begin
      w = mk(sll_pkg::ACT_LOCATE, $urandom, v);
      if (elem_count > 0 && $urandom_range(1))
        w.item_value = node_val[slot_at_pos($urandom_range(elem_count, 1))];
    end
    if ($urandom_range(19) == 0) w.position = 8'($urandom);
    return w;
  endfunction

  // receiver and checker
  always @(posedge clk) begin
    pend_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_data);
        end else begin
          e = pending_q.pop_front();
          if (out_data !== e.want || e.want !== e.pred) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h predicted %h actual %h",
                       e.want, e.pred, out_data);
          end
        end
      end
      out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    sll_pkg::in_word_t w;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b0;
    elem_count = 0;
    for (int i = 0; i < NODES; i++) begin
      node_link[i] = LINK_FREE;
      node_val[i] = '0;
    end
    node_link[0] = LINK_TAIL;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    add_row(mk(sll_pkg::ACT_DELETE, 1, 0), 1, mkr(sll_pkg::ST_EMPTY, 0, 0));
    add_row(mk(sll_pkg::ACT_GET, 1, 0), 1, mkr(sll_pkg::ST_EMPTY, 0, 0));
    add_row(mk(sll_pkg::ACT_LOCATE, 0, 0), 1, mkr(sll_pkg::ST_EMPTY, 0, 0));
    add_row(mk(sll_pkg::ACT_INSERT, 0, 5), 1, mkr(sll_pkg::ST_BAD_POS, 0, 0));
    add_row(mk(sll_pkg::ACT_INSERT, 2, 5), 1, mkr(sll_pkg::ST_BAD_POS, 0, 0));
    add_row(mk(sll_pkg::ACT_INSERT, 1, 32'h7fffffff), 1, mkr(sll_pkg::ST_OK, 0, 1));
    add_row(mk(sll_pkg::ACT_INSERT, 1, 32'h80000000), 1, mkr(sll_pkg::ST_OK, 0, 2));
    add_row(mk(sll_pkg::ACT_INSERT, 3, 32'hffffffff), 1, mkr(sll_pkg::ST_OK, 0, 3));
    add_row(mk(sll_pkg::ACT_INSERT, 2, 0), 1, mkr(sll_pkg::ST_OK, 0, 4));
    add_row(mk(sll_pkg::ACT_GET, 1, 0), 1, mkr(sll_pkg::ST_OK, 32'h80000000, 4));
    add_row(mk(sll_pkg::ACT_GET, 4, 0), 1, mkr(sll_pkg::ST_OK, 32'hffffffff, 4));
    add_row(mk(sll_pkg::ACT_GET, 0, 0), 1, mkr(sll_pkg::ST_BAD_POS, 0, 4));
    add_row(mk(sll_pkg::ACT_GET, 5, 0), 1, mkr(sll_pkg::ST_BAD_POS, 0, 4));
    add_row(mk(sll_pkg::ACT_GET, 255, 0), 1, mkr(sll_pkg::ST_BAD_POS, 0, 4));
    add_row(mk(sll_pkg::ACT_LOCATE, 0, 32'hffffffff), 0, '0);
    add_row(mk(sll_pkg::ACT_LOCATE, 0, 32'h12345678), 0, '0);
    add_row(mk(sll_pkg::ACT_DELETE, 0, 0), 1, mkr(sll_pkg::ST_BAD_POS, 0, 4));
    add_row(mk(sll_pkg::ACT_DELETE, 5, 0), 1, mkr(sll_pkg::ST_BAD_POS, 0, 4));
    add_row(mk(sll_pkg::ACT_DELETE, 2, 0), 1, mkr(sll_pkg::ST_OK, 0, 3));
    add_row(mk(sll_pkg::ACT_INSERT, 4, 32'h00000011), 0, '0);
    add_row(mk(sll_pkg::ACT_LOCATE, 255, 32'h00000011), 0, '0);
    add_row(mk(sll_pkg::ACT_DELETE, 1, 0), 0, '0);
    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 67; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      if (ph == 2) hold_go = 1'b1;
      for (n = 0; n < RAND_WORDS / 4; n++) begin
        w = rand_word();
        send_word(w, 0, '0);
      end
    end

    // fill the store to full
    while (elem_count < NODES - 1)
      send_word(mk(sll_pkg::ACT_INSERT, $urandom_range(elem_count + 1, 1), $urandom), 0, '0);
    send_word(mk(sll_pkg::ACT_INSERT, 1, 1), 1, mkr(sll_pkg::ST_FULL, 0, NODES - 1));
    send_word(mk(sll_pkg::ACT_GET, NODES - 1, 0), 0, '0);
    send_word(mk(sll_pkg::ACT_LOCATE, 0, node_val[slot_at_pos(NODES - 1)]), 0, '0);

    in_valid <= 1'b0;
    n = 0;
    while (pending_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
